@@ hdl/crlfq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlfq_pkg
// Shared types and constants of the CRLF line receive queue: the command and
// result transaction structs, operation codes and character codes.
// ----------------------------------------------------------------------------
package crlfq_pkg;

  // Default geometry of the line ring.
  localparam int unsigned LINE_SLOTS_DEF = 4;
  localparam int unsigned LINE_BYTES_DEF = 256;

  // Width of the configuration address. Register i sits at byte address 4*i.
  localparam int unsigned APB_AW = 3;

  // Register indexes.
  localparam logic REG_RAW_MODE = 1'b0;

  // Character codes.
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    OP_RECV    = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [7:0] read_offset;
  } cmd_t;

  typedef struct packed {
    logic       line_done;
    logic       dropped_oldest;
    logic [7:0] line_length;
    logic [1:0] lines_waiting;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       raw_pending;
  } res_t;

  // Configuration state handed from the register block to the datapath.
  typedef struct packed {
    logic raw_mode;
    logic clear;
  } cfg_t;

endpackage

@@ hdl/crlfq_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlfq_mem
// Byte store shared by the line slots and the raw ring: one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module crlfq_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/crlfq_apb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlfq_apb
// Configuration register block: holds the raw mode bit and signals a pointer
// clear on every write to it.
// ----------------------------------------------------------------------------
module crlfq_apb
  import crlfq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic raw_mode_q;
  logic wr_raw;

  assign pready = 1'b1;
  assign wr_raw = psel && penable && pwrite && (paddr[2] == REG_RAW_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q <= 1'b0;
    end else if (wr_raw) begin
      raw_mode_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RAW_MODE) begin
      prdata[0] = raw_mode_q;
    end
  end

  // The clear takes effect at the same edge as the write itself.
  assign cfg_o.raw_mode = raw_mode_q;
  assign cfg_o.clear    = wr_raw;

endmodule

@@ hdl/crlf_line_receive_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlf_line_receive_queue
// Frames received serial bytes into CRLF-terminated lines kept in a ring of
// line slots, or stores them in a single raw byte ring.
// ----------------------------------------------------------------------------
// The block takes one command transaction in every clock cycle; busy stays
// low. A transaction accepted at one edge is captured in the input register,
// processed in the following cycle, and its result is driven on res_o with
// done_o high during the cycle after that; the throughput is one transaction
// per cycle. This timing comes from the input register and the registered
// read port of the byte store. The result is shown for exactly one cycle and
// the receiver cannot stall it, so a consumer must take every strobe. The
// byte store has no reset and needs no clearing pass: only bytes written
// since the last mode write are ever read. Writing the raw mode register,
// even with its current value, clears all pointers and line lengths; do it
// only while no transaction is in flight.
// ----------------------------------------------------------------------------
module crlf_line_receive_queue
  import crlfq_pkg::*;
#(
  parameter int unsigned LINE_SLOTS = LINE_SLOTS_DEF,
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd_i,
  output logic              done_o,
  output res_t              res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned DEPTH = LINE_SLOTS * LINE_BYTES;
  localparam int unsigned SW    = $clog2(LINE_SLOTS);
  localparam int unsigned PW    = $clog2(LINE_BYTES);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = (PW > 8) ? PW : 8;

  localparam logic [SW-1:0] SLOT_LAST = SW'(LINE_SLOTS - 1);
  localparam logic [PW-1:0] POS_LIMIT = PW'(LINE_BYTES - 1);
  localparam logic [AW-1:0] RAW_LAST  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] SLOT_SPAN = AW'(LINE_BYTES);

  cfg_t cfg;

  // Input register.
  logic in_valid_q;
  cmd_t cmd_q;

  // Pointer state.
  logic [SW-1:0] ws_q, ws_d;
  logic [SW-1:0] rs_q, rs_d;
  logic [PW-1:0] wp_q, wp_d;
  logic          last_cr_q, last_cr_d;
  logic [AW-1:0] rwi_q, rwi_d;
  logic [AW-1:0] rri_q, rri_d;
  logic [PW-1:0] slot_len_q [LINE_SLOTS];

  // Line length write for a completed line.
  logic          len_we;
  logic [PW-1:0] len_wd;

  // Store ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Result register.
  logic res_valid_q;
  res_t res_q, res_d;
  logic read_hit_q, read_hit_d;

  logic [SW-1:0] ws_next;
  logic [SW-1:0] rs_next;
  logic [AW-1:0] rwi_next;
  logic [AW-1:0] rri_next;
  logic [SW-1:0] waiting;
  logic [PW-1:0] len_new;
  logic [CW-1:0] len_ext;
  logic [AW-1:0] line_waddr;
  logic [AW-1:0] line_raddr;

  crlfq_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  crlfq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Every transaction finishes in one pass, so the block never holds off.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
    end
  end

  // Wrapping successors of the slot and raw ring pointers.
  assign ws_next  = (ws_q == SLOT_LAST) ? '0 : ws_q + 1'b1;
  assign rs_next  = (rs_q == SLOT_LAST) ? '0 : rs_q + 1'b1;
  assign rwi_next = (rwi_q == RAW_LAST) ? '0 : rwi_q + 1'b1;
  assign rri_next = (rri_q == RAW_LAST) ? '0 : rri_q + 1'b1;

  // Store addresses of the current write position and the head line read.
  assign line_waddr = AW'(ws_q) * SLOT_SPAN + AW'(wp_q);
  assign line_raddr = AW'(rs_q) * SLOT_SPAN + AW'(cmd_q.read_offset);

  // The completed length drops the CR, which sits just below the LF.
  assign len_new = wp_q - 1'b1;
  assign len_ext = CW'(len_new);

  always_comb begin
    ws_d       = ws_q;
    rs_d       = rs_q;
    wp_d       = wp_q;
    last_cr_d  = last_cr_q;
    rwi_d      = rwi_q;
    rri_d      = rri_q;
    len_we     = 1'b0;
    len_wd     = len_new;
    mem_we     = 1'b0;
    mem_waddr  = line_waddr;
    mem_wdata  = cmd_q.rx_byte;
    mem_re     = 1'b0;
    mem_raddr  = line_raddr;
    read_hit_d = 1'b0;
    res_d      = '0;

    if (in_valid_q) begin
      case (cmd_q.operation)
        OP_RECV: begin
          if (cfg.raw_mode) begin
            mem_we    = 1'b1;
            mem_waddr = rwi_q;
            rwi_d     = rwi_next;
          end else if (cmd_q.rx_byte != CH_LF) begin
            // The last position of a slot is kept free; excess bytes drop.
            if (wp_q < POS_LIMIT) begin
              mem_we    = 1'b1;
              wp_d      = wp_q + 1'b1;
              last_cr_d = (cmd_q.rx_byte == CH_CR);
            end
          end else begin
            // LF: terminate the stored text and close or discard the line.
            mem_we    = 1'b1;
            mem_wdata = '0;
            wp_d      = '0;
            last_cr_d = 1'b0;
            if ((wp_q >= PW'(2)) && last_cr_q) begin
              len_we            = 1'b1;
              ws_d              = ws_next;
              res_d.line_done   = 1'b1;
              res_d.line_length = len_ext[7:0];
              // A full ring loses its oldest line to the new one.
              if (ws_next == rs_q) begin
                rs_d                 = rs_next;
                res_d.dropped_oldest = 1'b1;
              end
            end
          end
        end
        OP_READ: begin
          if (cfg.raw_mode) begin
            if (rri_q != rwi_q) begin
              mem_re           = 1'b1;
              mem_raddr        = rri_q;
              read_hit_d       = 1'b1;
              res_d.read_valid = 1'b1;
              rri_d            = rri_next;
            end
          end else if (ws_q != rs_q) begin
            res_d.read_valid = 1'b1;
            // Offsets at or past the line end read as zero.
            if (CW'(cmd_q.read_offset) < CW'(slot_len_q[rs_q])) begin
              mem_re     = 1'b1;
              read_hit_d = 1'b1;
            end
          end
        end
        OP_RELEASE: begin
          if (!cfg.raw_mode && (ws_q != rs_q)) begin
            rs_d = rs_next;
          end
        end
        default: begin
        end
      endcase
    end

    res_d.lines_waiting = 2'(waiting);
    res_d.raw_pending   = (rri_d != rwi_d);
  end

  // Lines waiting after this step, modulo the slot count.
  always_comb begin
    if (ws_d >= rs_d) begin
      waiting = ws_d - rs_d;
    end else begin
      waiting = SW'(ws_d + SLOT_LAST - rs_d + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q      <= '0;
      rs_q      <= '0;
      wp_q      <= '0;
      last_cr_q <= 1'b0;
      rwi_q     <= '0;
      rri_q     <= '0;
    end else if (cfg.clear) begin
      ws_q      <= '0;
      rs_q      <= '0;
      wp_q      <= '0;
      last_cr_q <= 1'b0;
      rwi_q     <= '0;
      rri_q     <= '0;
    end else begin
      ws_q      <= ws_d;
      rs_q      <= rs_d;
      wp_q      <= wp_d;
      last_cr_q <= last_cr_d;
      rwi_q     <= rwi_d;
      rri_q     <= rri_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINE_SLOTS; i++) begin
        slot_len_q[i] <= '0;
      end
    end else if (cfg.clear) begin
      for (int i = 0; i < LINE_SLOTS; i++) begin
        slot_len_q[i] <= '0;
      end
    end else if (len_we) begin
      slot_len_q[ws_q] <= len_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q      <= res_d;
      read_hit_q <= read_hit_d;
    end
  end

  // The read byte comes straight from the store's registered read port.
  always_comb begin
    res_o           = res_q;
    res_o.read_byte = read_hit_q ? mem_rdata : 8'h00;
  end

  assign done_o = res_valid_q;

`ifndef SYNTHESIS
  // An accepted transaction always produces its result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing after accepted transaction");

  // The oldest line is only overwritten by a line completion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.dropped_oldest) |-> res_o.line_done)
    else $error("dropped_oldest without line completion");

  // The write position never goes past the last usable slot position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= POS_LIMIT)
    else $error("write position beyond slot end");

  // A store read is only issued for a read command that found data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (in_valid_q && (cmd_q.operation == OP_READ) && res_d.read_valid))
    else $error("store read without a valid read command");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRLF line receive queue. Command transactions
// are driven through the start/busy port. An in-bench model of the line ring
// and the raw byte ring predicts the status of every command. Each strobed
// result is compared field by field against the oldest prediction. The mode
// register is written over the APB port only while the queue is quiet.
// ----------------------------------------------------------------------------
module tb;
  import crlfq_pkg::*;

  // Geometry of the instance under test, mirrored by the model below.
  localparam int unsigned NUM_SLOTS   = LINE_SLOTS_DEF;
  localparam int unsigned SLOT_BYTES  = LINE_BYTES_DEF;
  localparam int unsigned STORE_BYTES = NUM_SLOTS * SLOT_BYTES;

  // The fourth operation code has no function; it must only report status.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Byte address of the mode register on the APB port.
  localparam logic [APB_AW-1:0] RAW_MODE_ADDR = APB_AW'(4 * int'(REG_RAW_MODE));

  // The watchdog fires after this many cycles without any transaction.
  localparam int unsigned IDLE_LIMIT   = 2000;
  // Cycles allowed after the last result for any stray strobe to show up.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Mismatch lines beyond this count are still counted but not printed.
  localparam int unsigned MAX_REPORTS  = 100;

  // How a generated line is terminated.
  typedef enum int unsigned {
    END_CRLF,
    END_LF_ONLY,
    END_CR_CR_LF,
    END_NONE
  } line_end_e;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals of the queue. Every input has a known value
  // from time zero.
  // --------------------------------------------------------------------------
  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  cmd_t              cmd_i   = '0;
  logic              done_o;
  res_t              res_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  crlf_line_receive_queue dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Model of the queue. The byte store starts at zero, which the stimulus
  // never depends on: line reads stay within completed lines and raw reads
  // stay behind the write index.
  // --------------------------------------------------------------------------
  bit [7:0]    ring_bytes [STORE_BYTES];
  int unsigned slot_length [NUM_SLOTS];
  bit          cur_raw = 1'b0;
  int unsigned wslot   = 0;
  int unsigned rslot   = 0;
  int unsigned wpos    = 0;
  int unsigned raw_wr  = 0;
  int unsigned raw_rd  = 0;

  // Statuses predicted for accepted commands, oldest first.
  res_t        status_due [$];
  int unsigned items_sent  = 0;
  int unsigned bad_fields  = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on     = 1'b1;

  // Applies one command to the model and returns the status it produces.
  function automatic res_t frame_step(input cmd_t c);
    res_t        r;
    int unsigned len;
    r = '0;
    case (c.operation)
      OP_RECV: begin
        if (cur_raw) begin
          ring_bytes[raw_wr] = c.rx_byte;
          raw_wr = (raw_wr + 1) % STORE_BYTES;
        end else if (c.rx_byte != CH_LF) begin
          // The last position of a slot is never filled, so excess bytes
          // of an overlong line are lost.
          if (wpos < SLOT_BYTES - 1) begin
            ring_bytes[wslot * SLOT_BYTES + wpos] = c.rx_byte;
            wpos++;
          end
        end else begin
          ring_bytes[wslot * SLOT_BYTES + wpos] = '0;
          if (wpos >= 2 && ring_bytes[wslot * SLOT_BYTES + wpos - 1] == CH_CR) begin
            len = wpos - 1;
            ring_bytes[wslot * SLOT_BYTES + len] = '0;
            slot_length[wslot] = len;
            wpos = 0;
            wslot = (wslot + 1) % NUM_SLOTS;
            r.line_done = 1'b1;
            r.line_length = len[7:0];
            // A full ring loses its oldest unread line.
            if (rslot == wslot) begin
              rslot = (rslot + 1) % NUM_SLOTS;
              r.dropped_oldest = 1'b1;
            end
          end else begin
            wpos = 0;
          end
        end
      end
      OP_READ: begin
        if (cur_raw) begin
          if (raw_rd != raw_wr) begin
            r.read_byte = ring_bytes[raw_rd];
            r.read_valid = 1'b1;
            raw_rd = (raw_rd + 1) % STORE_BYTES;
          end
        end else if (wslot != rslot) begin
          r.read_valid = 1'b1;
          if (c.read_offset < slot_length[rslot]) begin
            r.read_byte = ring_bytes[rslot * SLOT_BYTES + c.read_offset];
          end
        end
      end
      OP_RELEASE: begin
        if (!cur_raw && wslot != rslot) begin
          rslot = (rslot + 1) % NUM_SLOTS;
        end
      end
      default: begin
      end
    endcase
    r.lines_waiting = 2'((wslot + NUM_SLOTS - rslot) % NUM_SLOTS);
    r.raw_pending = (raw_rd != raw_wr);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and the result checker. Results are sampled at the
  // rising edge that ends their strobe cycle.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    bad_fields++;
    if (bad_fields <= MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (status_due.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
      end else begin
        want = status_due.pop_front();
        check_field("line_done", 8'(res_o.line_done), 8'(want.line_done));
        check_field("dropped_oldest", 8'(res_o.dropped_oldest),
                    8'(want.dropped_oldest));
        check_field("line_length", res_o.line_length, want.line_length);
        check_field("lines_waiting", 8'(res_o.lines_waiting),
                    8'(want.lines_waiting));
        check_field("read_byte", res_o.read_byte, want.read_byte);
        check_field("read_valid", 8'(res_o.read_valid), 8'(want.read_valid));
        check_field("raw_pending", 8'(res_o.raw_pending), 8'(want.raw_pending));
      end
    end
  end

  // The watchdog restarts whenever a command is taken or a result appears.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left at a falling edge, so
  // inputs only ever change away from the rising edge at which they are sampled.
  // --------------------------------------------------------------------------

  // Gap before a command: usually none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Sends one command transaction and records its predicted status once the
  // queue has taken it. start is left high so the next command can follow
  // without a bubble.
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] data,
                          input logic [7:0] offset);
    cmd_t        c;
    int unsigned gap;
    c.operation   = op;
    c.rx_byte     = data;
    c.read_offset = offset;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    status_due.push_back(frame_step(c));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic recv(input logic [7:0] b);
    send_cmd(OP_RECV, b, 8'($urandom));
  endtask

  task automatic read_at(input logic [7:0] offset);
    send_cmd(OP_READ, 8'($urandom), offset);
  endtask

  // Holds the sender off until every outstanding status has come back.
  task automatic await_all_status();
    start <= 1'b0;
    while (status_due.size() != 0) @(negedge clk_i);
  endtask

  // Writes the mode register while nothing is in flight, then reads it back.
  // Any write clears every pointer and line length in the model as well.
  task automatic set_mode(input logic value);
    logic [31:0] readback;
    await_all_status();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RAW_MODE_ADDR;
    pwdata  <= {31'b0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    cur_raw = value;
    wslot   = 0;
    rslot   = 0;
    wpos    = 0;
    raw_wr  = 0;
    raw_rd  = 0;
    foreach (slot_length[i]) slot_length[i] = 0;
    // Read setup follows directly; psel stays high.
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[0] !== value) begin
      report_mismatch($sformatf("raw_mode reads back %0h after writing %0h",
                                readback[0], value));
    end
  endtask

  // Sends n text bytes that are never LF; CR appears only when allowed.
  task automatic send_content(input int unsigned n, input bit allow_cr);
    logic [7:0] b;
    repeat (n) begin
      if (allow_cr && $urandom_range(0, 24) == 0) begin
        b = CH_CR;
      end else begin
        do b = 8'($urandom); while (b == CH_LF || b == CH_CR);
      end
      recv(b);
    end
  endtask

  task automatic send_random_line(input int unsigned n, input line_end_e kind);
    send_content(n, 1'b1);
    case (kind)
      END_CRLF: begin
        recv(CH_CR);
        recv(CH_LF);
      end
      END_LF_ONLY: recv(CH_LF);
      END_CR_CR_LF: begin
        recv(CH_CR);
        recv(CH_CR);
        recv(CH_LF);
      end
      default: begin
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Line mode straight out of reset: empty queue, short and empty lines,
  // reads inside and past a line, and a ring that overflows.
  task automatic test_line_directed();
    read_at(8'h00);                 // no head line yet
    send_cmd(OP_RELEASE, 8'hFF, 8'hFF); // nothing to release
    send_cmd(OP_UNUSED, 8'hFF, 8'hFF);
    recv(CH_LF);                    // bare LF at position zero
    recv(CH_CR);
    recv(CH_LF);                    // empty CRLF line vanishes
    recv(8'h00);
    recv(CH_CR);
    recv(CH_LF);                    // one-byte line holding zero
    recv(8'hFF);
    recv(8'h41);
    recv(CH_CR);
    recv(CH_LF);
    read_at(8'h00);
    read_at(8'h01);                 // at the line end
    read_at(8'hFF);                 // far past the line end
    send_cmd(OP_RELEASE, 8'h00, 8'h00);
    read_at(8'h01);
    recv(8'h42);
    recv(8'h43);
    recv(CH_LF);                    // LF without CR drops the line
    // Two more lines fill the ring, the third overwrites the oldest.
    repeat (3) begin
      recv(8'($urandom_range(8'h20, 8'h7E)));
      recv(CH_CR);
      recv(CH_LF);
    end
    read_at(8'h00);
  endtask

  // Longest possible line, an overlong line that loses its CR, and an
  // overlong line whose last stored byte happens to be CR.
  task automatic test_long_lines();
    set_mode(1'b0);
    send_content(SLOT_BYTES - 2, 1'b0);
    recv(CH_CR);
    recv(CH_LF);
    read_at(8'(SLOT_BYTES - 3));
    read_at(8'(SLOT_BYTES - 2));
    read_at(8'h00);
    send_cmd(OP_RELEASE, 8'h00, 8'h00);
    send_content(300, 1'b0);
    recv(CH_CR);
    recv(CH_LF);
    send_content(SLOT_BYTES - 2, 1'b0);
    recv(CH_CR);
    send_content(10, 1'b0);
    recv(CH_LF);
    read_at(8'(SLOT_BYTES - 3));
  endtask

  // Raw mode basics: empty reads, ignored release and offset, control bytes
  // stored as plain data.
  task automatic test_raw_directed();
    set_mode(1'b1);
    read_at(8'h00);
    send_cmd(OP_RELEASE, 8'hFF, 8'hFF);
    send_cmd(OP_UNUSED, 8'h00, 8'h00);
    recv(8'h00);
    recv(8'hFF);
    recv(CH_LF);
    recv(CH_CR);
    recv(8'h5A);
    repeat (3) read_at(8'($urandom));
    send_cmd(OP_RELEASE, 8'h00, 8'h00);
    repeat (3) read_at(8'($urandom));
  endtask

  // A full wrap of the write index lands on the read index and the ring
  // looks empty again.
  task automatic test_raw_overrun();
    gaps_on = 1'b0;
    repeat (STORE_BYTES) recv(8'($urandom));
    gaps_on = 1'b1;
    read_at(8'h00);
    recv(8'($urandom));
    recv(8'($urandom));
    repeat (3) read_at(8'($urandom));
  endtask

  // Rewriting the mode, even with the same value, clears every pointer and
  // the partial line position.
  task automatic test_mode_clear();
    repeat (3) recv(8'($urandom));
    set_mode(1'b1);
    read_at(8'h00);
    set_mode(1'b0);
    repeat (2) begin
      recv(8'h51);
      recv(CH_CR);
      recv(CH_LF);
    end
    recv(8'h41);
    recv(8'h42);
    set_mode(1'b0);
    read_at(8'h00);
    recv(CH_CR);
    recv(CH_LF);
    read_at(8'h00);
  endtask

  // Mostly well-formed lines with random text, mixed with reads, releases
  // and random noise commands.
  task automatic test_random_lines(input int unsigned items);
    int unsigned target;
    int unsigned pick;
    int unsigned n;
    int unsigned e;
    bit          paused;
    line_end_e   kind;
    set_mode(1'b0);
    target = items_sent + items;
    paused = 1'b0;
    while (items_sent < target) begin
      if ($urandom_range(0, 29) == 0) gaps_on = !gaps_on;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        n = $urandom_range(0, 99);
        if (n < 80) n = $urandom_range(0, 10);
        else if (n < 99) n = $urandom_range(11, 60);
        else n = $urandom_range(250, 300);
        e = $urandom_range(0, 99);
        kind = (e < 80) ? END_CRLF : (e < 88) ? END_LF_ONLY :
               (e < 94) ? END_CR_CR_LF : END_NONE;
        send_random_line(n, kind);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 9) < 7) read_at(8'($urandom_range(0, slot_length[rslot] + 2)));
          else read_at(8'($urandom));
        end
      end else if (pick < 88) begin
        send_cmd(OP_RELEASE, 8'($urandom), 8'($urandom));
      end else begin
        send_cmd(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end
      // Once per phase the sender stops until the queue has answered all.
      if (!paused && items_sent >= target - items / 2) begin
        await_all_status();
        paused = 1'b1;
      end
    end
    gaps_on = 1'b1;
  endtask

  // Raw mode: bursts of writes and reads with random data and noise.
  task automatic test_random_raw(input int unsigned items);
    int unsigned target;
    int unsigned pick;
    bit          paused;
    set_mode(1'b1);
    target = items_sent + items;
    paused = 1'b0;
    while (items_sent < target) begin
      if ($urandom_range(0, 19) == 0) gaps_on = !gaps_on;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 10)) recv(8'($urandom));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 10)) read_at(8'($urandom));
      end else begin
        send_cmd(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end
      if (!paused && items_sent >= target - items / 2) begin
        await_all_status();
        paused = 1'b1;
      end
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. Reset is applied once; the mode moves between both values
  // several times, with a rewrite of the same value in between.
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_line_directed();
    test_long_lines();
    test_raw_directed();
    test_raw_overrun();
    test_mode_clear();
    test_random_lines(300);
    test_random_raw(150);
    test_random_lines(200);
    test_random_raw(100);

    // Let every outstanding status arrive, then watch for stray strobes.
    await_all_status();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (status_due.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived", status_due.size()));
    end
    if (bad_fields == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/crlfq_pkg.sv
hdl/crlfq_mem.sv
hdl/crlfq_apb.sv
hdl/crlf_line_receive_queue.sv
tb/tb.sv
